// ===== rtl/core/buffer_offset_stacking_placer_macros.svh =====
// Assertion macros used by the port-level checker of the placer.
// Requires a clock named clk and a reset named arst_n in scope.
`ifndef BUFFER_OFFSET_STACKING_PLACER_MACROS_SVH
`define BUFFER_OFFSET_STACKING_PLACER_MACROS_SVH
// Implication checked on every edge outside reset.
`define BOSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("placer check failed");
// Next-cycle implication checked outside reset.
`define BOSP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("placer check failed");
`endif

// ===== rtl/core/bosp_pkg.sv =====
// Shared types and constants of the buffer offset placer.
// No dependencies.
package bosp_pkg;
	localparam int unsigned MAX_BUFFERS_DEF = 256;
	localparam logic [31:0] CAPACITY_RST = 32'd2097152;
	localparam logic [16:0] ALIGNMENT_RST = 17'd128;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [0:0] REG_ALIGNMENT = 1'b1;
	localparam int unsigned SLOT_W = 8 + 32 + 33 + 32 + 32 + 3 + 8;

	typedef enum logic [3:0] {
		ST_IDLE, ST_P1_RD, ST_P1, ST_P2_RD, ST_P2, ST_P3_RD, ST_P3,
		ST_ALIGN, ST_FINISH, ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]  buf_id;
		logic [31:0] start;
		logic [32:0] fin;
		logic [31:0] size;
		logic [31:0] addr;
		logic        hp;
		logic        placed;
		logic        elig;
		logic [7:0]  parent;
	} slot_t;
endpackage

// ===== rtl/core/buffer_offset_stacking_placer.sv =====
// Buffer offset placer: greedy stacking with in-place reuse.
// Top level; uses bosp_pkg, bosp_ram, bosp_align.
//
// Channels: an input request (in_valid/in_ready) carries one buffer; a result
// (out_valid/out_ready) reports its address and the running plan totals. The
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// capacity (index 0) and alignment (index 1); other indexes are dropped.
// One item is worked on at a time. Each slot read takes a read step and a
// compare step: the eviction scan reads every slot, the partner search reads
// slots until a partner fits, each tried partner scans the other tops, and
// when no partner fits the alignment divider rounds the top up; a finish step
// loads the result. An evicted buffer skips the partner search; an ineligible
// buffer, or one arriving at a full table, goes straight to the finish step.
// The next request is taken once the result register is loaded, while the
// result still waits.
// Reset clears the slot count and totals; the slot RAM needs no clearing.
// A stalled receiver holds the result; a further item then waits in its
// finish step until the result register frees.
module buffer_offset_stacking_placer #(
	parameter int unsigned MAX_BUFFERS = bosp_pkg::MAX_BUFFERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  buffer_id,
	input  logic [31:0] first_tick,
	input  logic [32:0] stop_tick,
	input  logic [31:0] size,
	input  logic        eligible,
	input  logic [15:0] use_count,
	input  logic        first_use_read,
	input  logic        has_parent,
	input  logic [7:0]  parent_id,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  placed_id,
	output logic        placed,
	output logic [31:0] address,
	output logic [63:0] quality_halves,
	output logic [8:0]  placed_count,
	output logic        plan_done
);
	localparam int unsigned AW = $clog2(MAX_BUFFERS);
	localparam int unsigned CW = AW + 1;

	bosp_pkg::state_t state_q, state_d;
	logic [31:0] capacity_q;
	logic [16:0] alignment_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q, k_q;
	logic [63:0] qsum_q;
	logic [8:0]  ptot_q;

	// latched request
	logic [7:0]  bid_q, pid_q;
	logic [31:0] st_q, sz_q;
	logic [32:0] en_q;
	logic [15:0] uc_q;
	logic        el_q, fr_q, hp_q, last_q;

	logic        evict_q;
	logic [32:0] max_top_q, others_q, addr_q;
	logic [31:0] paddr_q;
	logic [48:0] wq_s1;

	logic        ram_we;
	logic [AW-1:0] ram_raddr;
	bosp_pkg::slot_t ram_wdata, rd;

	logic        al_start, al_done;
	logic [33:0] al_result;

	logic        cand, rd_top_ok;
	logic [32:0] rd_top;
	logic        mine, theirs, size_ok;
	logic        do_finish, can_place, fin_placed;
	logic [33:0] fin_end;
	logic [64:0] qsum_add;

	bosp_ram #(.WIDTH(bosp_pkg::SLOT_W), .DEPTH(MAX_BUFFERS)) u_slots (
		.clk(clk), .we(ram_we), .waddr(count_q[AW-1:0]), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rd)
	);

	bosp_align u_align (
		.clk(clk), .arst_n(arst_n), .start(al_start), .value(max_top_q),
		.align(alignment_q), .done(al_done), .result(al_result)
	);

	assign cand = rd.elig && ({1'b0, st_q} < rd.fin) && ({1'b0, rd.start} < en_q);
	assign rd_top = {1'b0, rd.addr} + {1'b0, rd.size};
	assign mine = hp_q && (pid_q == rd.buf_id);
	assign theirs = rd.hp && (rd.parent == bid_q);
	assign size_ok = mine ? (sz_q <= rd.size) : (rd.size <= sz_q);
	assign rd_top_ok = cand && (mine || theirs) && size_ok;
	assign can_place = el_q && (count_q < CW'(MAX_BUFFERS)) && !evict_q;
	assign fin_end = {1'b0, addr_q} + {2'b0, sz_q};
	assign fin_placed = can_place && (fin_end <= {2'b0, capacity_q});
	assign do_finish = (state_q == bosp_pkg::ST_FINISH) && (!out_valid || out_ready);
	assign qsum_add = {1'b0, qsum_q} + {16'b0, wq_s1};

	assign cfg_ready = (state_q == bosp_pkg::ST_IDLE);
	assign in_ready = (state_q == bosp_pkg::ST_IDLE);
	assign al_start = (state_q == bosp_pkg::ST_P2_RD) && !evict_q && (j_q == count_q);
	assign ram_we = do_finish && (count_q < CW'(MAX_BUFFERS));
	assign ram_raddr = (state_q == bosp_pkg::ST_P3 || state_q == bosp_pkg::ST_P3_RD)
		? k_q[AW-1:0] : j_q[AW-1:0];

	always_comb begin
		ram_wdata.buf_id = bid_q;
		ram_wdata.start = st_q;
		ram_wdata.fin = en_q;
		ram_wdata.size = sz_q;
		ram_wdata.addr = fin_placed ? addr_q[31:0] : 32'd0;
		ram_wdata.hp = hp_q;
		ram_wdata.placed = fin_placed;
		ram_wdata.elig = el_q;
		ram_wdata.parent = pid_q;
	end

	// P1: evict/max top scan. P2: partner search. P3: other-tops scan for one partner.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bosp_pkg::ST_IDLE: if (in_valid) state_d = bosp_pkg::ST_P1_RD;
			bosp_pkg::ST_P1_RD: begin
				if (!el_q || count_q == CW'(MAX_BUFFERS)) state_d = bosp_pkg::ST_FINISH;
				else if (j_q == count_q) state_d = bosp_pkg::ST_P2_RD;
				else state_d = bosp_pkg::ST_P1;
			end
			bosp_pkg::ST_P1: state_d = bosp_pkg::ST_P1_RD;
			bosp_pkg::ST_P2_RD: begin
				if (evict_q) state_d = bosp_pkg::ST_FINISH;
				else if (j_q == count_q) state_d = bosp_pkg::ST_ALIGN;
				else state_d = bosp_pkg::ST_P2;
			end
			bosp_pkg::ST_P2: state_d = rd_top_ok ? bosp_pkg::ST_P3_RD : bosp_pkg::ST_P2_RD;
			bosp_pkg::ST_P3_RD: state_d = bosp_pkg::ST_P3;
			bosp_pkg::ST_P3: begin
				if (k_q == count_q) state_d = (others_q <= {1'b0, paddr_q})
					? bosp_pkg::ST_FINISH : bosp_pkg::ST_P2_RD;
				else state_d = bosp_pkg::ST_P3_RD;
			end
			bosp_pkg::ST_ALIGN: if (al_done) state_d = bosp_pkg::ST_FINISH;
			bosp_pkg::ST_FINISH: if (do_finish) state_d = bosp_pkg::ST_IDLE;
			default: state_d = bosp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bosp_pkg::ST_IDLE;
			capacity_q <= bosp_pkg::CAPACITY_RST;
			alignment_q <= bosp_pkg::ALIGNMENT_RST;
			count_q <= '0;
			qsum_q <= '0;
			ptot_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bosp_pkg::REG_CAPACITY: capacity_q <= cfg_data;
					bosp_pkg::REG_ALIGNMENT: alignment_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (do_finish) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (do_finish) begin
				if (last_q) begin
					count_q <= '0;
					qsum_q <= '0;
					ptot_q <= '0;
				end else begin
					if (count_q < CW'(MAX_BUFFERS)) count_q <= count_q + CW'(1);
					if (fin_placed) begin
						qsum_q <= qsum_add[64] ? '1 : qsum_add[63:0];
						if (ptot_q != 9'd511) ptot_q <= ptot_q + 9'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_finish) begin
			placed_id <= bid_q;
			placed <= fin_placed;
			address <= fin_placed ? addr_q[31:0] : 32'd0;
			plan_done <= last_q;
			if (fin_placed) begin
				quality_halves <= qsum_add[64] ? '1 : qsum_add[63:0];
				placed_count <= (ptot_q != 9'd511) ? ptot_q + 9'd1 : ptot_q;
			end else begin
				quality_halves <= qsum_q;
				placed_count <= ptot_q;
			end
		end
		case (state_q)
			bosp_pkg::ST_IDLE: begin
				bid_q <= buffer_id; st_q <= first_tick; en_q <= stop_tick;
				sz_q <= size; el_q <= eligible; uc_q <= use_count;
				fr_q <= first_use_read; hp_q <= has_parent; pid_q <= parent_id;
				last_q <= last;
				j_q <= '0; evict_q <= 1'b0;
				max_top_q <= '0; addr_q <= '0;
			end
			bosp_pkg::ST_P1_RD: begin
				wq_s1 <= {32'd0, uc_q, !fr_q} * {17'd0, sz_q};
				if (j_q == count_q) j_q <= '0;
			end
			bosp_pkg::ST_P1: begin
				j_q <= j_q + CW'(1);
				if (cand) begin
					if (!rd.placed) evict_q <= 1'b1;
					else if (rd_top > max_top_q) max_top_q <= rd_top;
				end
			end
			bosp_pkg::ST_P2_RD: ;
			bosp_pkg::ST_P2: begin
				j_q <= j_q + CW'(1);
				k_q <= '0;
				others_q <= '0;
				paddr_q <= rd.addr;
			end
			bosp_pkg::ST_P3_RD: ;
			bosp_pkg::ST_P3: begin
				if (k_q == count_q) begin
					if (others_q <= {1'b0, paddr_q}) addr_q <= {1'b0, paddr_q};
				end else begin
					k_q <= k_q + CW'(1);
					if (k_q != j_q - CW'(1) && cand && rd_top > others_q)
						others_q <= rd_top;
				end
			end
			bosp_pkg::ST_ALIGN: if (al_done) addr_q <= al_result[33] ? '1 : al_result[32:0];
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/bosp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bosp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/bosp_align.sv =====
// Iterative round-up to a multiple of the alignment, one quotient bit a cycle.
// Depends on nothing but its ports.
module bosp_align (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] value,
	input  logic [16:0] align,
	output logic        done,
	output logic [33:0] result
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] num_q;
	logic [33:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] a_q;
	logic [17:0] rem_sh;
	logic [50:0] prod;
	logic [33:0] quo_up;

	assign rem_sh = {rem_q[16:0], num_q[33]};
	assign quo_up = quo_q + 34'(rem_q != 18'd0);
	assign prod = quo_up * {17'd0, a_q};
	assign result = prod[33:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {1'b0, value};
			quo_q <= '0;
			rem_q <= '0;
			a_q <= (align == 17'd0) ? 17'd1 : align;
		end else if (busy_q) begin
			num_q <= {num_q[32:0], 1'b0};
			if (rem_sh >= {1'b0, a_q}) begin
				rem_q <= rem_sh - {1'b0, a_q};
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/bosp_checker.sv =====
// Port-level checks of the buffer offset placer, bound to the top level.
// Depends on buffer_offset_stacking_placer_macros.svh.
`include "buffer_offset_stacking_placer_macros.svh"
module bosp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        placed,
	input logic [31:0] address,
	input logic [8:0]  placed_count
);
	`BOSP_ASSERT_IMP(a_addr_zero, out_valid && !placed, address == 32'd0)
	`BOSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(address))
	`BOSP_ASSERT_IMP(a_cnt_placed, out_valid && placed, placed_count != 9'd0)
	`BOSP_ASSERT_NXT(a_one_busy, in_valid && in_ready, !in_ready)
endmodule

bind buffer_offset_stacking_placer bosp_checker u_bosp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .placed(placed),
	.address(address), .placed_count(placed_count)
);

// ===== tb/sv/buffer_offset_stacking_placer_checker.sv =====
// Checker for the buffer offset placer: watches the config, request and result
// channels, predicts each placement and compares it with the result.
// Depends on bosp_pkg.
`timescale 1ns / 100ps

module buffer_offset_stacking_placer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  buffer_id,
	input  logic [31:0] first_tick,
	input  logic [32:0] stop_tick,
	input  logic [31:0] size,
	input  logic        eligible,
	input  logic [15:0] use_count,
	input  logic        first_use_read,
	input  logic        has_parent,
	input  logic [7:0]  parent_id,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  placed_id,
	input  logic        placed,
	input  logic [31:0] address,
	input  logic [63:0] quality_halves,
	input  logic [8:0]  placed_count,
	input  logic        plan_done,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [7:0]  id;
		logic        placed;
		logic [31:0] addr;
		logic [63:0] quality;
		logic [8:0]  count;
		logic        done;
	} placement_t;

	logic [31:0] capacity_reg;
	logic [16:0] align_reg;

	// plan table of buffers seen so far
	int unsigned tab_used;
	logic [7:0]  tab_id[bosp_pkg::MAX_BUFFERS_DEF];
	logic [31:0] tab_start[bosp_pkg::MAX_BUFFERS_DEF];
	logic [32:0] tab_end[bosp_pkg::MAX_BUFFERS_DEF];
	logic [31:0] tab_size[bosp_pkg::MAX_BUFFERS_DEF];
	logic [31:0] tab_addr[bosp_pkg::MAX_BUFFERS_DEF];
	logic        tab_elig[bosp_pkg::MAX_BUFFERS_DEF];
	logic        tab_placed[bosp_pkg::MAX_BUFFERS_DEF];
	logic        tab_haspar[bosp_pkg::MAX_BUFFERS_DEF];
	logic [7:0]  tab_parent[bosp_pkg::MAX_BUFFERS_DEF];
	logic [63:0] quality_acc;
	logic [8:0]  placed_acc;

	placement_t expected_placements[$];

	assign pending = expected_placements.size();

	function automatic bit overlaps(int unsigned j, logic [31:0] st, logic [32:0] en);
		return tab_elig[j] && ({1'b0, st} < tab_end[j]) && ({1'b0, tab_start[j]} < en);
	endfunction

	function automatic logic [63:0] top_of(int unsigned j);
		return 64'(tab_addr[j]) + 64'(tab_size[j]);
	endfunction

	function automatic placement_t place_buffer();
		placement_t r;
		bit evict, found, mine, theirs, ok;
		logic [63:0] max_top, others, a, addr, q;
		logic [31:0] par_sz, child_sz;
		int unsigned j, k, slot;
		ok = 0;
		addr = 0;
		if (eligible && tab_used < bosp_pkg::MAX_BUFFERS_DEF) begin
			evict = 0;
			found = 0;
			max_top = 0;
			for (j = 0; j < tab_used; j++) begin
				if (!overlaps(j, first_tick, stop_tick)) continue;
				if (!tab_placed[j]) evict = 1;
				else if (top_of(j) > max_top) max_top = top_of(j);
			end
			if (!evict) begin
				for (j = 0; j < tab_used && !found; j++) begin
					mine = has_parent && parent_id == tab_id[j];
					theirs = tab_haspar[j] && tab_parent[j] == buffer_id;
					if (!overlaps(j, first_tick, stop_tick) || !(mine || theirs)) continue;
					if (mine) begin
						par_sz = tab_size[j];
						child_sz = size;
					end else begin
						par_sz = size;
						child_sz = tab_size[j];
					end
					if (child_sz > par_sz) continue;
					others = 0;
					for (k = 0; k < tab_used; k++) begin
						if (k == j || !overlaps(k, first_tick, stop_tick)) continue;
						if (top_of(k) > others) others = top_of(k);
					end
					if (others <= 64'(tab_addr[j])) begin
						found = 1;
						addr = 64'(tab_addr[j]);
					end
				end
				if (!found) begin
					a = (align_reg == 0) ? 64'd1 : 64'(align_reg);
					addr = ((max_top + a - 1) / a) * a;
				end
				ok = (addr + 64'(size)) <= 64'(capacity_reg);
			end
			if (!ok) addr = 0;
		end
		if (tab_used < bosp_pkg::MAX_BUFFERS_DEF) begin
			slot = tab_used;
			tab_id[slot] = buffer_id;
			tab_start[slot] = first_tick;
			tab_end[slot] = stop_tick;
			tab_size[slot] = size;
			tab_addr[slot] = addr[31:0];
			tab_elig[slot] = eligible;
			tab_placed[slot] = ok;
			tab_haspar[slot] = has_parent;
			tab_parent[slot] = parent_id;
			tab_used++;
		end
		if (ok) begin
			q = (64'(use_count) * 2 + (first_use_read ? 64'd0 : 64'd1)) * 64'(size);
			quality_acc = (quality_acc > ~q) ? '1 : quality_acc + q;
			if (placed_acc < 9'd511) placed_acc++;
		end
		r.id = buffer_id;
		r.placed = ok;
		r.addr = addr[31:0];
		r.quality = quality_acc;
		r.count = placed_acc;
		r.done = last;
		if (last) begin
			tab_used = 0;
			quality_acc = 0;
			placed_acc = 0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			capacity_reg <= bosp_pkg::CAPACITY_RST;
			align_reg <= bosp_pkg::ALIGNMENT_RST;
			tab_used = 0;
			quality_acc = 0;
			placed_acc = 0;
			expected_placements.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_placements.size() == 0) begin
					report_mismatch("unexpected result id", 64'(placed_id), 0);
				end else begin
					want = expected_placements.pop_front();
					if (placed_id !== want.id)
						report_mismatch("placed_id", 64'(placed_id), 64'(want.id));
					if (placed !== want.placed)
						report_mismatch("placed", 64'(placed), 64'(want.placed));
					if (address !== want.addr)
						report_mismatch("address", 64'(address), 64'(want.addr));
					if (quality_halves !== want.quality)
						report_mismatch("quality_halves", quality_halves, want.quality);
					if (placed_count !== want.count)
						report_mismatch("placed_count", 64'(placed_count), 64'(want.count));
					if (plan_done !== want.done)
						report_mismatch("plan_done", 64'(plan_done), 64'(want.done));
				end
			end
			if (in_valid && in_ready)
				expected_placements.insert(expected_placements.size(), place_buffer());
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bosp_pkg::REG_CAPACITY) capacity_reg <= cfg_data;
				else if (cfg_index == bosp_pkg::REG_ALIGNMENT) align_reg <= cfg_data[16:0];
			end
		end
	end
endmodule

// ===== tb/sv/buffer_offset_stacking_placer_test.sv =====
// Top of the placer testbench: clock, reset, config writes, buffer plans and
// the verdict. Uses bosp_pkg and buffer_offset_stacking_placer_checker.
`timescale 1ns / 100ps

module buffer_offset_stacking_placer_test;
	localparam int CYCLE_LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = bosp_pkg::REG_CAPACITY;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  buffer_id = '0;
	logic [31:0] first_tick = '0;
	logic [32:0] stop_tick = 33'd1;
	logic [31:0] size = '0;
	logic        eligible = 1'b0;
	logic [15:0] use_count = 16'd1;
	logic        first_use_read = 1'b0;
	logic        has_parent = 1'b0;
	logic [7:0]  parent_id = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  placed_id;
	logic        placed;
	logic [31:0] address;
	logic [63:0] quality_halves;
	logic [8:0]  placed_count;
	logic        plan_done;

	int errors;
	int pending;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;

	buffer_offset_stacking_placer u_dut (.*);

	buffer_offset_stacking_placer_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_buffer(logic [7:0] id, logic [31:0] st, logic [32:0] en,
			logic [31:0] sz, logic el, logic [15:0] uc, logic fr, logic hp,
			logic [7:0] pid, logic lst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		buffer_id = id;
		first_tick = st;
		stop_tick = en;
		size = sz;
		eligible = el;
		use_count = uc;
		first_use_read = fr;
		has_parent = hp;
		parent_id = pid;
		last = lst;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_noise(logic lst);
		logic [32:0] en;
		logic [15:0] uc;
		en = {1'($urandom), 32'($urandom)};
		if (en[32]) en[31:0] = '0;
		if (en == 0) en = 33'd1;
		uc = 16'($urandom);
		if (uc == 0) uc = 16'd1;
		send_buffer(8'($urandom), $urandom, en, $urandom, 1'($urandom), uc,
			1'($urandom), 1'($urandom), 8'($urandom), lst);
	endtask

	// plan of consecutive ids with short overlapping intervals and in-place pairs
	task automatic run_plan(int n, bit with_parents);
		logic [7:0] base, pid;
		logic [31:0] st, sz;
		bit hp;
		int i;
		base = 8'($urandom);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(11) == 0) begin
				send_noise(i == n - 1);
				continue;
			end
			st = $urandom_range(0, 48);
			sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2048);
			case ($urandom_range(9))
				0, 1, 2, 3: begin hp = 1; pid = base + 8'($urandom_range(0, i)); end
				4, 5:       begin hp = 1; pid = base + 8'(i + $urandom_range(1, 3)); end
				6:          begin hp = 1; pid = 8'($urandom); end
				default:    begin hp = 0; pid = 8'($urandom); end
			endcase
			if (!with_parents) hp = 0;
			send_buffer(base + 8'(i), st, 33'(st) + 33'($urandom_range(1, 24)), sz,
				$urandom_range(11) != 0, 16'($urandom_range(1, 8)), 1'($urandom),
				hp, pid, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int ph, left, n;
		logic [31:0] caps[4];
		logic [31:0] aligns[4];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan under a small scratchpad
		write_reg(bosp_pkg::REG_CAPACITY, 32'd4096);
		write_reg(bosp_pkg::REG_ALIGNMENT, 32'd64);
		send_buffer(8'd1, 32'd0, 33'd10, 32'd100, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		send_buffer(8'd2, 32'd5, 33'd15, 32'd200, 1'b1, 16'd2, 1'b0, 1'b0, 8'd0, 1'b0);
		// ineligible
		send_buffer(8'd3, 32'd0, 33'd10, 32'd64, 1'b0, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		// child reuses parent slot
		send_buffer(8'd4, 32'd8, 33'd12, 32'd50, 1'b1, 16'd1, 1'b1, 1'b1, 8'd2, 1'b0);
		send_buffer(8'd6, 32'd20, 33'd30, 32'd300, 1'b1, 16'd1, 1'b0, 1'b1, 8'd7, 1'b0);
		// parent named by earlier child
		send_buffer(8'd7, 32'd25, 33'd35, 32'd400, 1'b1, 16'd3, 1'b1, 1'b0, 8'd0, 1'b0);
		send_buffer(8'd8, 32'd40, 33'd50, 32'd100, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		// child too large
		send_buffer(8'd9, 32'd45, 33'd55, 32'd500, 1'b1, 16'd1, 1'b1, 1'b1, 8'd8, 1'b0);
		// beyond capacity
		send_buffer(8'd10, 32'd60, 33'd70, 32'd5000, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		// evicted by overlap
		send_buffer(8'd11, 32'd65, 33'd75, 32'd10, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		// empty interval
		send_buffer(8'd12, 32'd80, 33'd80, 32'd10, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		send_buffer(8'd13, 32'd90, 33'd5, 32'd10, 1'b1, 16'd1, 1'b1, 1'b0, 8'd0, 1'b0);
		// self parent
		send_buffer(8'd14, 32'd100, 33'd110, 32'd10, 1'b1, 16'd1, 1'b1, 1'b1, 8'd14, 1'b0);
		// duplicate id
		send_buffer(8'd14, 32'd105, 33'd115, 32'd10, 1'b1, 16'd1, 1'b1, 1'b1, 8'd14, 1'b0);
		send_buffer(8'd20, 32'd300, 33'd310, 32'd64, 1'b1, 16'd1, 1'b1, 1'b1, 8'd21, 1'b0);
		// pair named both ways
		send_buffer(8'd21, 32'd300, 33'd310, 32'd32, 1'b1, 16'd1, 1'b1, 1'b1, 8'd20, 1'b0);
		send_buffer(8'd0, 32'd200, 33'd201, 32'd0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0);
		send_buffer(8'd255, 32'hFFFFFFFF, 33'h100000000, 32'hFFFFFFFF, 1'b1, 16'hFFFF,
			1'b0, 1'b1, 8'hFF, 1'b1);
		wait_drained();

		// fill the table past its depth
		write_reg(bosp_pkg::REG_CAPACITY, 32'hFFFFFFFF);
		write_reg(bosp_pkg::REG_ALIGNMENT, 32'd1);
		run_plan(bosp_pkg::MAX_BUFFERS_DEF + 4, 1'b0);
		wait_drained();

		caps = '{32'd0, 32'hFFFFFFFF, bosp_pkg::CAPACITY_RST, 32'd65536};
		aligns = '{32'd1, 32'd65536, 32'd0, 32'hFFFE0080};
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 68; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 68; end
				default: begin send_idle = 12; recv_stall = 12; end
			endcase
			write_reg(bosp_pkg::REG_CAPACITY, (ph < 4) ? caps[ph] : $urandom);
			write_reg(bosp_pkg::REG_ALIGNMENT,
				(ph < 4) ? aligns[ph] : $urandom_range(1, 65536));
			left = 95;
			while (left > 0) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
				if (n > left) n = left;
				run_plan(n, 1'b1);
				left -= n;
			end
			wait_drained();
		end

		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bosp_pkg.sv
rtl/core/bosp_ram.sv
rtl/core/bosp_align.sv
rtl/core/buffer_offset_stacking_placer.sv
rtl/core/bosp_checker.sv
tb/sv/buffer_offset_stacking_placer_checker.sv
tb/sv/buffer_offset_stacking_placer_test.sv
